@@ hw/rtl/brdt_pkg.sv @@
// Types and constants for the block rewrite distance tracker.
// No dependencies; imported by block_rewrite_distance_tracker_core.
package brdt_pkg;

	localparam int ADDR_W  = 20;
	localparam int INDEX_W = ADDR_W;
	localparam int NEXT_W  = ADDR_W + 1;
	localparam int SEQ_W   = 48;
	localparam int COUNT_W = 48;
	localparam int TOTAL_W = 64;
	localparam int DIST_W  = 29;
	localparam int SQ_W    = 2 * DIST_W;

	// distance unit is 4096 / 16 = 256 writes
	localparam int DIST_UNIT  = 4096 / 16;
	localparam int DIST_SHIFT = $clog2(DIST_UNIT);
	localparam int QUOT_W     = SEQ_W - DIST_SHIFT;

	localparam int unsigned DEPTH = 1 << ADDR_W;

	localparam logic [NEXT_W-1:0]  BLOCK_COUNT = NEXT_W'(DEPTH);
	localparam logic [SEQ_W-1:0]   SEQ_MAX     = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
	localparam logic [DIST_W-1:0]  DIST_MAX    = '1;
	localparam logic [ADDR_W-1:0]  CLR_LAST    = '1;

	// per-address row: last write sequence (zero = never written) and dense index
	typedef struct packed {
		logic [SEQ_W-1:0]   seq;
		logic [INDEX_W-1:0] idx;
	} addr_row_t;

	// per-index statistics row
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TOTAL_W-1:0] dist_total;
		logic [TOTAL_W-1:0] sq_total;
	} stat_row_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_UPD
	} state_t;

endpackage

@@ hw/rtl/block_rewrite_distance_tracker_core.sv @@
// Block rewrite distance tracker: address table and per-index statistics table,
// each a synchronous-read memory, updated by read-modify-write.
// Each word passes ST_RD_A, ST_RD_B and ST_UPD; the result is then registered.
// A new word is taken only back in ST_IDLE, after the two dependent memory reads
// (address row, then statistics row), squaring and an update that may stall.
// Reset: after arst_n releases, a clearing pass of 2^20 cycles zeroes both tables;
// no input word is taken during it.
// Depends on brdt_pkg.
module block_rewrite_distance_tracker_core
	import brdt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ADDR_W-1:0]   block_address,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                is_new,
	output logic [INDEX_W-1:0]  block_index,
	output logic [DIST_W-1:0]   distance_mib,
	output logic [COUNT_W-1:0]  rewrite_count
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0]  clr_q;
	logic [SEQ_W-1:0]   wr_seq_q;
	logic [NEXT_W-1:0]  next_free_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [INDEX_W-1:0] idx_q;
	logic               is_new_q;
	logic [DIST_W-1:0]  dist_q;
	logic [SQ_W-1:0]    sq_q;
	stat_row_t          stat_q;
	logic               out_valid_q;
	logic               out_is_new_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic [DIST_W-1:0]  out_dist_q;
	logic [COUNT_W-1:0] out_count_q;

	// memories
	addr_row_t mem_a [DEPTH];
	stat_row_t mem_b [DEPTH];
	addr_row_t a_rdata_q;
	stat_row_t b_rdata_q;

	logic              a_re, a_we, b_re, b_we;
	logic [ADDR_W-1:0] a_raddr, a_waddr;
	logic [ADDR_W-1:0] b_raddr, b_waddr;
	addr_row_t         a_wdata;
	stat_row_t         b_wdata;

	logic               accept, upd_go;
	logic               rd_new;
	logic [INDEX_W-1:0] rd_idx;
	logic [SEQ_W-1:0]   seq_next;
	logic [SEQ_W-1:0]   seq_diff;
	logic [QUOT_W-1:0]  quot;
	logic [DIST_W-1:0]  dist_sat;
	logic [COUNT_W-1:0] count_new;
	logic [TOTAL_W:0]   dist_sum, sq_sum;
	stat_row_t          stat_new;

	assign accept = in_valid && in_ready;
	assign upd_go = (state_q == ST_UPD) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_RD_A;
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_UPD;
			ST_UPD: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// address row lookup
	always_comb begin
		rd_new   = (a_rdata_q.seq == '0);
		rd_idx   = rd_new ? next_free_q[INDEX_W-1:0] : a_rdata_q.idx;
		seq_next = (wr_seq_q == SEQ_MAX) ? wr_seq_q : wr_seq_q + SEQ_W'(1);
		seq_diff = (wr_seq_q >= a_rdata_q.seq) ? (wr_seq_q - a_rdata_q.seq) : '0;
		quot     = seq_diff[SEQ_W-1:DIST_SHIFT];
		if (quot > QUOT_W'(DIST_MAX)) begin
			dist_sat = DIST_MAX;
		end else begin
			dist_sat = quot[DIST_W-1:0];
		end
		if (rd_new) dist_sat = '0;
	end

	// statistics update, saturating
	always_comb begin
		count_new = (stat_q.count == COUNT_MAX) ? stat_q.count : stat_q.count + COUNT_W'(1);
		dist_sum  = {1'b0, stat_q.dist_total} + (TOTAL_W + 1)'(dist_q);
		sq_sum    = {1'b0, stat_q.sq_total} + (TOTAL_W + 1)'(sq_q);
		stat_new.count      = is_new_q ? stat_q.count : count_new;
		stat_new.dist_total = dist_sum[TOTAL_W] ? TOTAL_MAX : dist_sum[TOTAL_W-1:0];
		stat_new.sq_total   = sq_sum[TOTAL_W] ? TOTAL_MAX : sq_sum[TOTAL_W-1:0];
	end

	// memory port control
	always_comb begin
		a_re    = accept;
		a_raddr = block_address;
		a_we    = 1'b0;
		a_waddr = addr_q;
		a_wdata = '{seq: seq_next, idx: rd_idx};
		b_re    = (state_q == ST_RD_A);
		b_raddr = rd_idx;
		b_we    = 1'b0;
		b_waddr = idx_q;
		b_wdata = stat_new;
		if (state_q == ST_CLEAR) begin
			a_we    = 1'b1;
			a_waddr = clr_q;
			a_wdata = '0;
			b_we    = 1'b1;
			b_waddr = clr_q;
			b_wdata = '0;
		end else begin
			a_we = (state_q == ST_RD_A);
			b_we = upd_go && !is_new_q;
		end
	end

	always_ff @(posedge clk) begin
		if (a_we) mem_a[a_waddr] <= a_wdata;
		if (a_re) a_rdata_q <= mem_a[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we) mem_b[b_waddr] <= b_wdata;
		if (b_re) b_rdata_q <= mem_b[b_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			wr_seq_q    <= '0;
			next_free_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (state_q == ST_RD_A) begin
				wr_seq_q <= seq_next;
				if (rd_new && next_free_q < BLOCK_COUNT) next_free_q <= next_free_q + NEXT_W'(1);
			end
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) addr_q <= block_address;
		if (state_q == ST_RD_A) begin
			idx_q    <= rd_idx;
			is_new_q <= rd_new;
			dist_q   <= dist_sat;
		end
		if (state_q == ST_RD_B) begin
			stat_q <= b_rdata_q;
			sq_q   <= dist_q * dist_q;
		end
		if (upd_go) begin
			out_is_new_q <= is_new_q;
			out_idx_q    <= idx_q;
			out_dist_q   <= dist_q;
			out_count_q  <= stat_new.count;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_new        = out_is_new_q;
	assign block_index   = out_idx_q;
	assign distance_mib  = out_dist_q;
	assign rewrite_count = out_count_q;

	// checks
	a_new_no_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_new) |-> (distance_mib == '0))
		else $error("new address word carries a distance");

	a_rewrite_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_new) |-> (rewrite_count != '0))
		else $error("rewrite word with zero count");

	a_seq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_A) |=> (wr_seq_q != '0))
		else $error("write sequence zero after a write");

	a_next_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= BLOCK_COUNT)
		else $error("free index beyond table");

	a_out_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_UPD))
		else $error("result raised outside update step");

endmodule
